// ===== hdl/q2e_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_pkg : shared constants, types and tables for the quaternion to Euler unit
// Fixed-point formats, the CORDIC arctangent table and the record that
// carries the trigonometric terms through the pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

   // field widths
   localparam int QUAT_W  = 16;
   localparam int ROLL_W  = 15;
   localparam int PITCH_W = 14;
   localparam int YAW_W   = 15;
   localparam int PROD_W  = 32;   // one 16x16 product

   // trigonometric terms, Q28
   localparam int TERM_W    = 34;
   localparam int ROOTARG_W = 33; // saturated root argument, non-negative

   // square root: argument shifted to Q56, one result digit per step
   localparam int ROOT_FRAC = 28;
   localparam int SQ_W      = 63;
   localparam int SQ_STEPS  = 32;
   localparam int ROOT_W    = 31;

   // CORDIC
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 31;
   localparam int CORDIC_ITER  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int VEC_W        = 40;
   localparam int ANG_W        = 36;  // Q30 radians

   localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;

   // output limits, Q12
   localparam int ROLL_LIM  = 12868;
   localparam int PITCH_LIM = 6434;

   typedef struct packed {
      logic signed [TERM_W-1:0] sin_roll;
      logic signed [TERM_W-1:0] cos_roll;
      logic signed [TERM_W-1:0] sin_yaw;
      logic signed [TERM_W-1:0] cos_yaw;
   } atan_in_type;

   typedef struct packed {
      atan_in_type          roll_yaw;
      logic [ROOTARG_W-1:0] pitch_plus;   // max(0, 1 + 2t)
      logic [ROOTARG_W-1:0] pitch_minus;  // max(0, 1 - 2t)
   } terms_type;

   // atan(2^-i) in Q30
   function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned idx);
      logic signed [ANG_W-1:0] val;
      case (idx)
         0:  val = 36'sd843314857;
         1:  val = 36'sd497837829;
         2:  val = 36'sd263043836;
         3:  val = 36'sd133525158;
         4:  val = 36'sd67021686;
         5:  val = 36'sd33543515;
         6:  val = 36'sd16775850;
         7:  val = 36'sd8388437;
         8:  val = 36'sd4194282;
         9:  val = 36'sd2097149;
         10: val = 36'sd1048575;
         11: val = 36'sd524287;
         12: val = 36'sd262143;
         13: val = 36'sd131071;
         14: val = 36'sd65535;
         15: val = 36'sd32767;
         16: val = 36'sd16383;
         17: val = 36'sd8191;
         18: val = 36'sd4095;
         19: val = 36'sd2047;
         20: val = 36'sd1023;
         21: val = 36'sd511;
         22: val = 36'sd255;
         23: val = 36'sd127;
         24: val = 36'sd63;
         25: val = 36'sd31;
         26: val = 36'sd15;
         27: val = 36'sd8;
         28: val = 36'sd4;
         29: val = 36'sd2;
         30: val = 36'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage : q2e_pkg
`default_nettype wire

// ===== hdl/q2e_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_if : request and response channels of the quaternion to Euler unit
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface q2e_req_if
   import q2e_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [QUAT_W-1:0] quat_w;
   logic signed [QUAT_W-1:0] quat_x;
   logic signed [QUAT_W-1:0] quat_y;
   logic signed [QUAT_W-1:0] quat_z;

   modport source (output valid, output quat_w, output quat_x, output quat_y,
                   output quat_z, input ready);
   modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                   input quat_z, output ready);
endinterface : q2e_req_if

interface q2e_rsp_if
   import q2e_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [ROLL_W-1:0]  roll_angle;
   logic signed [PITCH_W-1:0] pitch_angle;
   logic signed [YAW_W-1:0]   yaw_angle;

   modport source (output valid, output roll_angle, output pitch_angle,
                   output yaw_angle, input ready);
   modport sink   (input valid, input roll_angle, input pitch_angle,
                   input yaw_angle, output ready);
endinterface : q2e_rsp_if
`default_nettype wire

// ===== hdl/quaternion_to_euler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit : unit quaternion to roll, pitch and yaw
// Q1.14 quaternion in, Q2.12 radians out (pitch Q1.12); atan2 and square roots by
// pipelined digit-per-stage units.
// ----------------------------------------------------------------------------
//  channel   direction  transaction payload
//  req_port  in         quat_w, quat_x, quat_y, quat_z   (Q1.14)
//  rsp_port  out        roll_angle, pitch_angle, yaw_angle (Q2.12, pitch Q1.12)
//
//  One transaction per cycle while the output is not stalled. The stages are the
//  products and sums, the 32-digit square root, the CORDIC, and the rounding
//  stage that is also the output register.
//  A stalled output freezes the whole pipeline; req_port.ready follows.
//  Synchronous reset empties the pipeline; no data state is kept.
// ----------------------------------------------------------------------------
module quaternion_to_euler_unit
   import q2e_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   q2e_req_if.sink    req_port,
   q2e_rsp_if.source  rsp_port
);

   localparam int LAT   = 2 + SQ_STEPS + CORDIC_ITER + 1;
   localparam int PANG_W = ANG_W + 2;
   localparam int RND_W  = PANG_W - 18;
   localparam logic signed [PANG_W-1:0] RND_HALF = PANG_W'(64'sd131072);
   localparam logic signed [RND_W-1:0]  ROLL_MAX  = RND_W'(ROLL_LIM);
   localparam logic signed [RND_W-1:0]  PITCH_MAX = RND_W'(PITCH_LIM);

   logic                    adv;
   logic [LAT-1:0]          vld_ff;
   logic                    rsp_valid_ff;
   terms_type               terms;
   logic [ROOT_W-1:0]       root_plus, root_minus;
   atan_in_type             dly_ff [SQ_STEPS];
   logic signed [ANG_W-1:0] roll_z, pitch_z, yaw_z;
   logic signed [RND_W-1:0] roll_in, pitch_in, yaw_in;
   logic signed [ROLL_W-1:0]  roll_ff;
   logic signed [PITCH_W-1:0] pitch_ff;
   logic signed [YAW_W-1:0]   yaw_ff;

   // round Q30 to Q12 half up, then clamp
   function automatic logic signed [RND_W-1:0] round_q12(
      input logic signed [PANG_W-1:0] a,
      input logic signed [RND_W-1:0]  lim
   );
      logic signed [PANG_W-1:0] sum;
      logic signed [RND_W-1:0]  r;
      sum = a + RND_HALF;
      r   = RND_W'(sum >>> 18);
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

   // whole pipeline moves unless the output holds an untaken result
   assign adv            = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = adv;

   // valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[LAT-2:0], req_port.valid};
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   q2e_terms u_terms (
      .clock  (clock),
      .en     (adv),
      .quat_w (req_port.quat_w),
      .quat_x (req_port.quat_x),
      .quat_y (req_port.quat_y),
      .quat_z (req_port.quat_z),
      .terms  (terms)
   );

   q2e_isqrt u_sqrt_plus (
      .clock (clock),
      .en    (adv),
      .arg   (terms.pitch_plus),
      .root  (root_plus)
   );

   q2e_isqrt u_sqrt_minus (
      .clock (clock),
      .en    (adv),
      .arg   (terms.pitch_minus),
      .root  (root_minus)
   );

   // roll and yaw terms wait for the square roots
   always_ff @(posedge clock) begin
      if (adv) begin
         dly_ff[0] <= terms.roll_yaw;
         for (int k = 1; k < SQ_STEPS; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   q2e_cordic u_roll (
      .clock (clock),
      .en    (adv),
      .vec_y (VEC_W'(dly_ff[SQ_STEPS-1].sin_roll)),
      .vec_x (VEC_W'(dly_ff[SQ_STEPS-1].cos_roll)),
      .angle (roll_z)
   );

   q2e_cordic u_pitch (
      .clock (clock),
      .en    (adv),
      .vec_y ($signed(VEC_W'(root_plus))),
      .vec_x ($signed(VEC_W'(root_minus))),
      .angle (pitch_z)
   );

   q2e_cordic u_yaw (
      .clock (clock),
      .en    (adv),
      .vec_y (VEC_W'(dly_ff[SQ_STEPS-1].sin_yaw)),
      .vec_x (VEC_W'(dly_ff[SQ_STEPS-1].cos_yaw)),
      .angle (yaw_z)
   );

   // rounding and output register
   assign roll_in  = round_q12(PANG_W'(roll_z), ROLL_MAX);
   assign pitch_in = round_q12((PANG_W'(pitch_z) <<< 1) - PANG_W'(HALF_PI_Q30), PITCH_MAX);
   assign yaw_in   = round_q12(PANG_W'(yaw_z), ROLL_MAX);

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff  <= roll_in[ROLL_W-1:0];
         pitch_ff <= pitch_in[PITCH_W-1:0];
         yaw_ff   <= yaw_in[YAW_W-1:0];
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.roll_angle  = roll_ff;
   assign rsp_port.pitch_angle = pitch_ff;
   assign rsp_port.yaw_angle   = yaw_ff;

   // checks
   a_clamp : assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (pitch_ff <= PITCH_W'(PITCH_LIM)) && (pitch_ff >= -PITCH_W'(PITCH_LIM))
                      && (roll_ff <= ROLL_W'(ROLL_LIM)) && (roll_ff >= -ROLL_W'(ROLL_LIM)))
      else $error("angle outside clamp range");

   a_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && !rsp_port.ready) |-> !req_port.ready)
      else $error("input taken while output stalled");

   a_drain : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAT-1] && adv) |=> rsp_port.valid)
      else $error("transaction lost at output stage");

   a_reset : assert property (@(posedge clock)
      reset |=> (!rsp_port.valid && (vld_ff == '0)))
      else $error("pipeline not empty after reset");

endmodule : quaternion_to_euler_unit
`default_nettype wire

// ===== hdl/q2e_terms.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_terms : products and sums of the quaternion components
// Stage one registers the nine products, stage two the sine/cosine terms and
// the saturated square-root arguments for pitch.
// ----------------------------------------------------------------------------
module q2e_terms
   import q2e_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic signed [QUAT_W-1:0] quat_w,
   input  wire logic signed [QUAT_W-1:0] quat_x,
   input  wire logic signed [QUAT_W-1:0] quat_y,
   input  wire logic signed [QUAT_W-1:0] quat_z,
   output      terms_type                terms
);

   localparam int ARG_W = TERM_W + 1;
   localparam logic signed [TERM_W-1:0] ONE_TERM = TERM_W'(64'sd268435456);
   localparam logic signed [ARG_W-1:0]  ONE_ARG  = ARG_W'(64'sd268435456);

   logic signed [PROD_W-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, xz_ff;
   logic signed [TERM_W-1:0] t_diff;
   logic signed [ARG_W-1:0]  plus_raw, minus_raw;
   terms_type                terms_in, terms_ff;

   // stage 1: products
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= PROD_W'(quat_w) * PROD_W'(quat_x);
         yz_ff <= PROD_W'(quat_y) * PROD_W'(quat_z);
         xx_ff <= PROD_W'(quat_x) * PROD_W'(quat_x);
         yy_ff <= PROD_W'(quat_y) * PROD_W'(quat_y);
         wz_ff <= PROD_W'(quat_w) * PROD_W'(quat_z);
         xy_ff <= PROD_W'(quat_x) * PROD_W'(quat_y);
         zz_ff <= PROD_W'(quat_z) * PROD_W'(quat_z);
         wy_ff <= PROD_W'(quat_w) * PROD_W'(quat_y);
         xz_ff <= PROD_W'(quat_x) * PROD_W'(quat_z);
      end
   end

   // stage 2: sums, root arguments clamped at zero
   always_comb begin
      terms_in.roll_yaw.sin_roll = (TERM_W'(wx_ff) + TERM_W'(yz_ff)) <<< 1;
      terms_in.roll_yaw.cos_roll = ONE_TERM - ((TERM_W'(xx_ff) + TERM_W'(yy_ff)) <<< 1);
      terms_in.roll_yaw.sin_yaw  = (TERM_W'(wz_ff) + TERM_W'(xy_ff)) <<< 1;
      terms_in.roll_yaw.cos_yaw  = ONE_TERM - ((TERM_W'(yy_ff) + TERM_W'(zz_ff)) <<< 1);
      t_diff    = TERM_W'(wy_ff) - TERM_W'(xz_ff);
      plus_raw  = ONE_ARG + (ARG_W'(t_diff) <<< 1);
      minus_raw = ONE_ARG - (ARG_W'(t_diff) <<< 1);
      terms_in.pitch_plus  = plus_raw[ARG_W-1]  ? '0 : plus_raw[ROOTARG_W-1:0];
      terms_in.pitch_minus = minus_raw[ARG_W-1] ? '0 : minus_raw[ROOTARG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         terms_ff <= terms_in;
      end
   end

   assign terms = terms_ff;

endmodule : q2e_terms
`default_nettype wire

// ===== hdl/q2e_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_isqrt : pipelined floor square root
// Argument is shifted to Q56; one result digit per stage, SQ_STEPS stages.
// ----------------------------------------------------------------------------
module q2e_isqrt
   import q2e_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [ROOTARG_W-1:0] arg,
   output      logic [ROOT_W-1:0]    root
);

   logic [SQ_W-1:0] rem_ff [SQ_STEPS-1];
   logic [SQ_W-1:0] res_ff [SQ_STEPS];

   for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
      localparam logic [SQ_W-1:0] DIGIT = SQ_W'(1) << (SQ_W - 1 - 2 * s);
      logic [SQ_W-1:0] rem_cur, res_cur, trial;
      logic            take;

      if (s == 0) begin : g_first
         assign rem_cur = SQ_W'(arg) << ROOT_FRAC;
         assign res_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[s-1];
         assign res_cur = res_ff[s-1];
      end

      assign trial = res_cur + DIGIT;
      assign take  = (rem_cur >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            res_ff[s] <= take ? ((res_cur >> 1) + DIGIT) : (res_cur >> 1);
         end
      end

      // the last remainder is not needed
      if (s < SQ_STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= take ? (rem_cur - trial) : rem_cur;
            end
         end
      end
   end

   assign root = res_ff[SQ_STEPS-1][ROOT_W-1:0];

endmodule : q2e_isqrt
`default_nettype wire

// ===== hdl/q2e_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_cordic : pipelined vectoring CORDIC, atan2(y, x) in Q30 radians
// One pre-rotation stage for the left half plane, then one stage per step.
// ----------------------------------------------------------------------------
module q2e_cordic
   import q2e_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic signed [VEC_W-1:0] vec_y,
   input  wire logic signed [VEC_W-1:0] vec_x,
   output      logic signed [ANG_W-1:0] angle
);

   logic signed [VEC_W-1:0] x_ff [CORDIC_ITER];
   logic signed [VEC_W-1:0] y_ff [CORDIC_ITER];
   logic signed [ANG_W-1:0] z_ff [CORDIC_ITER+1];
   logic                    zero_ff [CORDIC_ITER+1];

   // pre-rotation by pi when x is negative
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (vec_x == '0) && (vec_y == '0);
         if (vec_x < 0) begin
            x_ff[0] <= -vec_x;
            y_ff[0] <= -vec_y;
            z_ff[0] <= (vec_y >= 0) ? PI_Q30 : -PI_Q30;
         end else begin
            x_ff[0] <= vec_x;
            y_ff[0] <= vec_y;
            z_ff[0] <= '0;
         end
      end
   end

   // micro-rotations
   for (genvar i = 0; i < CORDIC_ITER; i++) begin : g_iter
      localparam logic signed [ANG_W-1:0] ATAN_I = atan_q30(i);
      logic                    up;

      assign up = (y_ff[i] > 0);

      always_ff @(posedge clock) begin
         if (en) begin
            z_ff[i+1]    <= up ? (z_ff[i] + ATAN_I) : (z_ff[i] - ATAN_I);
            zero_ff[i+1] <= zero_ff[i];
         end
      end

      if (i < CORDIC_ITER - 1) begin : g_vec
         logic signed [VEC_W-1:0] dx, dy;

         assign dx = y_ff[i] >>> i;
         assign dy = x_ff[i] >>> i;

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[i+1] <= up ? (x_ff[i] + dx) : (x_ff[i] - dx);
               y_ff[i+1] <= up ? (y_ff[i] - dy) : (y_ff[i] + dy);
            end
         end
      end
   end

   // atan2(0, 0) is zero
   assign angle = zero_ff[CORDIC_ITER] ? '0 : z_ff[CORDIC_ITER];

endmodule : q2e_cordic
`default_nettype wire
